@@ design/focs_pkg.sv @@
// Shared types, constants and helper functions for the FOC current loop.
`timescale 1ns / 1ps
package focs_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned CURRENT_WIDTH = 16;

  // Angle quantization ahead of the polynomial sine (power of two entries per turn)
  localparam int unsigned SINE_TABLE_ENTRIES = 1024;
  localparam int unsigned AngStep = 65536 / SINE_TABLE_ENTRIES;
  localparam logic [15:0] ANG_MASK = ~16'(AngStep - 1);

  // Quarter-wave sine polynomial coefficients, unsigned Q1.15
  localparam logic [15:0] SIN_A = 16'd51437;
  localparam logic [15:0] SIN_B = 16'd20953;
  localparam logic [15:0] SIN_C = 16'd2285;

  // 1/sqrt3 scaled by 2^16, voltage limit in Q1.15
  localparam logic [16:0] INV_SQRT3_Q16 = 17'd37837;
  localparam logic [14:0] VOLT_LIMIT = 15'd27810;
  localparam logic [29:0] VOLT_LIMIT_SQ = 30'd773396100;
  localparam int unsigned VOLT_WIDTH = 24;

  // Iteration counts of the square root and divide sequences
  localparam int unsigned SQRT_STEPS = 25;
  localparam int unsigned DIV_STEPS = 16;

  // Configuration register indexes
  localparam logic [1:0] REG_KP   = 2'd0;
  localparam logic [1:0] REG_KI   = 2'd1;
  localparam logic [1:0] REG_HALF = 2'd2;
  localparam logic [1:0] REG_DEAD = 2'd3;

  // Datapath operation codes
  localparam logic [5:0] OP_NOP      = 6'd0;
  localparam logic [5:0] OP_LOAD     = 6'd1;
  localparam logic [5:0] OP_SIN_X2   = 6'd2;
  localparam logic [5:0] OP_SIN_U    = 6'd3;
  localparam logic [5:0] OP_SIN_W    = 6'd4;
  localparam logic [5:0] OP_SIN_Y    = 6'd5;
  localparam logic [5:0] OP_CLARKE   = 6'd6;
  localparam logic [5:0] OP_PD1      = 6'd7;
  localparam logic [5:0] OP_PD2      = 6'd8;
  localparam logic [5:0] OP_PQ1      = 6'd9;
  localparam logic [5:0] OP_PQ2      = 6'd10;
  localparam logic [5:0] OP_ERR      = 6'd11;
  localparam logic [5:0] OP_VD       = 6'd12;
  localparam logic [5:0] OP_VQ       = 6'd13;
  localparam logic [5:0] OP_M2A      = 6'd14;
  localparam logic [5:0] OP_M2B      = 6'd15;
  localparam logic [5:0] OP_INTD     = 6'd16;
  localparam logic [5:0] OP_INTQ     = 6'd17;
  localparam logic [5:0] OP_SQ_STEP  = 6'd18;
  localparam logic [5:0] OP_DIV_INIT = 6'd19;
  localparam logic [5:0] OP_DIV_STEP = 6'd20;
  localparam logic [5:0] OP_DIV_END  = 6'd21;
  localparam logic [5:0] OP_IBUS1    = 6'd22;
  localparam logic [5:0] OP_IBUS2    = 6'd23;
  localparam logic [5:0] OP_IPA1     = 6'd24;
  localparam logic [5:0] OP_IPA2     = 6'd25;
  localparam logic [5:0] OP_IPB1     = 6'd26;
  localparam logic [5:0] OP_IPB2     = 6'd27;
  localparam logic [5:0] OP_BK       = 6'd28;
  localparam logic [5:0] OP_SEXT     = 6'd29;
  localparam logic [5:0] OP_T1       = 6'd30;
  localparam logic [5:0] OP_T2       = 6'd31;
  localparam logic [5:0] OP_T0       = 6'd32;
  localparam logic [5:0] OP_TS       = 6'd33;
  localparam logic [5:0] OP_OUT      = 6'd34;

  // Command from the sequencer: operation plus axis/angle select
  typedef struct packed {
    logic [5:0] op;
    logic       sel;
  } focs_cmd_t;

  // Status back to the sequencer
  typedef struct packed {
    logic limited;
  } focs_stat_t;

  // Saturate to w signed bits
  function automatic logic signed [63:0] sat_s(logic signed [63:0] v, int unsigned w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Arithmetic shift right with round half up
  function automatic logic signed [63:0] rnd_s(logic signed [63:0] v, int unsigned s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

endpackage

@@ design/focs_ctrl.sv @@
// Sequencer for the FOC current loop: steps the datapath through one PWM update.
`timescale 1ns / 1ps
module focs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  input  focs_pkg::focs_stat_t   stat_i,
  output focs_pkg::focs_cmd_t    cmd_o
);
  import focs_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [4:0] PC_BRANCH = 5'd19;
  localparam logic [4:0] PC_LAST   = 5'd31;

  logic [2:0] state_q, state_d;
  logic [4:0] pc_q, pc_d;
  logic [5:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic [5:0] run_op;
  logic       run_sel;

  // Straight-line program of the run phase
  always_comb begin
    run_sel = (pc_q >= 5'd4) && (pc_q <= 5'd7);
    case (pc_q)
      5'd0, 5'd4:  run_op = OP_SIN_X2;
      5'd1, 5'd5:  run_op = OP_SIN_U;
      5'd2, 5'd6:  run_op = OP_SIN_W;
      5'd3, 5'd7:  run_op = OP_SIN_Y;
      5'd8:        run_op = OP_CLARKE;
      5'd9:        run_op = OP_PD1;
      5'd10:       run_op = OP_PD2;
      5'd11:       run_op = OP_PQ1;
      5'd12:       run_op = OP_PQ2;
      5'd13:       run_op = OP_ERR;
      5'd14:       run_op = OP_VD;
      5'd15:       run_op = OP_VQ;
      5'd16:       run_op = OP_M2A;
      5'd17:       run_op = OP_M2B;
      5'd18:       run_op = OP_INTD;
      5'd19:       run_op = OP_INTQ;
      5'd20:       run_op = OP_IBUS1;
      5'd21:       run_op = OP_IBUS2;
      5'd22:       run_op = OP_IPA1;
      5'd23:       run_op = OP_IPA2;
      5'd24:       run_op = OP_IPB1;
      5'd25:       run_op = OP_IPB2;
      5'd26:       run_op = OP_BK;
      5'd27:       run_op = OP_SEXT;
      5'd28:       run_op = OP_T1;
      5'd29:       run_op = OP_T2;
      5'd30:       run_op = OP_T0;
      5'd31:       run_op = OP_TS;
      default:     run_op = OP_NOP;
    endcase
  end

  // Next state and command
  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NOP;
    cmd_o.sel  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_RUN;
          pc_d     = '0;
        end
      end
      ST_RUN: begin
        cmd_o.op  = run_op;
        cmd_o.sel = run_sel;
        pc_d      = 5'(pc_q + 5'd1);
        if (pc_q == PC_BRANCH && stat_i.limited) begin
          state_d = ST_SQRT;
          cnt_d   = '0;
        end else if (pc_q == PC_LAST) begin
          state_d = ST_OUT;
        end
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQ_STEP;
        cnt_d    = 6'(cnt_q + 6'd1);
        if (cnt_q == 6'(SQRT_STEPS - 1)) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        // d axis first, then q axis: init, steps, sign fix
        cmd_o.sel = (cnt_q > 6'(DIV_STEPS + 1));
        cnt_d     = 6'(cnt_q + 6'd1);
        if (cnt_q == 6'd0 || cnt_q == 6'(DIV_STEPS + 2)) begin
          cmd_o.op = OP_DIV_INIT;
        end else if (cnt_q == 6'(DIV_STEPS + 1) || cnt_q == 6'(2 * DIV_STEPS + 3)) begin
          cmd_o.op = OP_DIV_END;
        end else begin
          cmd_o.op = OP_DIV_STEP;
        end
        if (cnt_q == 6'(2 * DIV_STEPS + 3)) begin
          state_d = ST_RUN;
          pc_d    = 5'(PC_BRANCH + 5'd1);
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/focs_dp.sv @@
// Datapath of the FOC current loop: shared multiplier, sqrt and divide steps, SVM.
`timescale 1ns / 1ps
module focs_dp #(
  parameter int unsigned CurrentWidth = focs_pkg::CURRENT_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  focs_pkg::focs_cmd_t  cmd_i,
  output focs_pkg::focs_stat_t stat_o,
  input  logic [15:0]          kp_i,
  input  logic [15:0]          ki_i,
  input  logic [15:0]          half_period_i,
  input  logic [9:0]           dead_time_i,
  input  logic signed [15:0]   target_d_i,
  input  logic signed [15:0]   target_q_i,
  input  logic signed [15:0]   current_a_i,
  input  logic signed [15:0]   current_b_i,
  input  logic [15:0]          rotor_angle_i,
  output logic [15:0]          phase_a_on_o,
  output logic [15:0]          phase_a_off_o,
  output logic [15:0]          phase_b_on_o,
  output logic [15:0]          phase_b_off_o,
  output logic [15:0]          phase_c_on_o,
  output logic [15:0]          phase_c_off_o,
  output logic signed [31:0]   bus_current_estimate_o,
  output logic                 voltage_limited_o
);
  import focs_pkg::*;

  localparam int unsigned CW = CurrentWidth;
  localparam int unsigned EW = ((CW > 16) ? CW : 16) + 1;

  localparam logic [2:0] SX1 = 3'd1;
  localparam logic [2:0] SX2 = 3'd2;
  localparam logic [2:0] SX3 = 3'd3;
  localparam logic [2:0] SX4 = 3'd4;
  localparam logic [2:0] SX5 = 3'd5;
  localparam logic [2:0] SX6 = 3'd6;

  // Item registers
  logic [15:0]            p_q;
  logic signed [15:0]     td_q, tq_q, ia_q, ib_q;
  logic [15:0]            x2_q, u_q, w_q;
  logic signed [15:0]     s_q, c_q;
  logic signed [CW-1:0]   ial_q, ibe_q, id_q, iq_q;
  logic signed [EW-1:0]   ed_q, eq_q;
  logic signed [49:0]     acc_q;
  logic signed [23:0]     vd_q, vq_q;
  logic signed [31:0]     integ_d_q, integ_q_q;
  logic                   lim_q;
  logic [48:0]            rem_q, res_q, sq_bit_q;
  logic [39:0]            num_q;
  logic [40:0]            dsh_q;
  logic [15:0]            quo_q;
  logic signed [31:0]     ibus_q;
  logic signed [17:0]     va_q, vb_q;
  logic signed [35:0]     bk_q;
  logic [2:0]             sxt_q;
  logic signed [36:0]     n1_q, n2_q;
  logic [17:0]            t1_q, t2_q;
  logic [19:0]            t0h_q, ta_q, tb_q, tc_q;
  logic [15:0]            a_on_q, a_off_q, b_on_q, b_off_q, c_on_q, c_off_q;
  logic signed [31:0]     out_ibus_q;
  logic                   out_lim_q;

  // Sine argument folding
  logic [15:0]        ang;
  logic [14:0]        fr;
  logic [15:0]        sx;
  always_comb begin
    ang = cmd_i.sel ? 16'(p_q + 16'd16384) : p_q;
    fr  = ang[14] ? 15'(15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    sx  = {fr, 1'b0};
  end

  // Shared multiplier with operand select
  logic signed [36:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [61:0] prod;
  logic signed [63:0] p64;
  logic signed [23:0] vabs;
  always_comb begin
    vabs  = cmd_i.sel ? ((vq_q < 0) ? -vq_q : vq_q) : ((vd_q < 0) ? -vd_q : vd_q);
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SIN_X2:   begin mul_a = 37'(sx);    mul_b = 25'(sx);    end
      OP_SIN_U:    begin mul_a = 37'(SIN_C); mul_b = 25'(x2_q);  end
      OP_SIN_W:    begin mul_a = 37'(x2_q);  mul_b = 25'(u_q);   end
      OP_SIN_Y:    begin mul_a = 37'(sx);    mul_b = 25'(w_q);   end
      OP_CLARKE:   begin
        mul_a = 37'(ia_q) + (37'(ib_q) <<< 1);
        mul_b = 25'(INV_SQRT3_Q16);
      end
      OP_PD1:      begin mul_a = 37'(c_q);   mul_b = 25'(ial_q); end
      OP_PD2:      begin mul_a = 37'(s_q);   mul_b = 25'(ibe_q); end
      OP_PQ1:      begin mul_a = 37'(c_q);   mul_b = 25'(ibe_q); end
      OP_PQ2:      begin mul_a = 37'(s_q);   mul_b = 25'(ial_q); end
      OP_VD:       begin mul_a = 37'(kp_i);  mul_b = 25'(ed_q);  end
      OP_VQ:       begin mul_a = 37'(kp_i);  mul_b = 25'(eq_q);  end
      OP_M2A:      begin mul_a = 37'(vd_q);  mul_b = 25'(vd_q);  end
      OP_M2B:      begin mul_a = 37'(vq_q);  mul_b = 25'(vq_q);  end
      OP_INTD:     begin mul_a = 37'(ki_i);  mul_b = 25'(ed_q);  end
      OP_INTQ:     begin mul_a = 37'(ki_i);  mul_b = 25'(eq_q);  end
      OP_DIV_INIT: begin mul_a = 37'(vabs);  mul_b = 25'(VOLT_LIMIT); end
      OP_IBUS1:    begin mul_a = 37'(vd_q);  mul_b = 25'(id_q);  end
      OP_IBUS2:    begin mul_a = 37'(vq_q);  mul_b = 25'(iq_q);  end
      OP_IPA1:     begin mul_a = 37'(c_q);   mul_b = 25'(vd_q);  end
      OP_IPA2:     begin mul_a = 37'(s_q);   mul_b = 25'(vq_q);  end
      OP_IPB1:     begin mul_a = 37'(c_q);   mul_b = 25'(vq_q);  end
      OP_IPB2:     begin mul_a = 37'(s_q);   mul_b = 25'(vd_q);  end
      OP_BK:       begin mul_a = 37'(vb_q);  mul_b = 25'(INV_SQRT3_Q16); end
      OP_T1:       begin mul_a = n1_q; mul_b = 25'(half_period_i); end
      OP_T2:       begin mul_a = n2_q; mul_b = 25'(half_period_i); end
      default:     begin mul_a = '0;   mul_b = '0; end
    endcase
    prod = 62'(mul_a) * 62'(mul_b);
    p64  = 64'(prod);
  end

  // Post-multiply results
  logic signed [63:0] acc64, sh15, yv, m2_sum, tv, t0v;
  logic signed [15:0] sin_val;
  logic [48:0]        m2_new, sq_try;
  logic               lim_new;
  always_comb begin
    acc64  = 64'(acc_q);
    sh15   = p64 >>> 15;
    yv     = (sh15 > 64'sd32767) ? 64'sd32767 : sh15;
    sin_val = ang[15] ? 16'(-yv) : 16'(yv);
    m2_sum = acc64 + p64;
    m2_new = 49'(m2_sum);
    lim_new = m2_new > 49'(VOLT_LIMIT_SQ);
    sq_try = 49'(res_q + sq_bit_q);
    tv     = p64 >>> 31;
    t0v    = 64'(half_period_i) - 64'(t1_q) - 64'(t2_q);
  end

  // Sextant selection and vector numerators
  logic signed [63:0] big_a, big_bk, big_b2, n1v, n2v;
  logic [2:0]         sxt_new;
  always_comb begin
    big_a  = 64'(va_q) <<< 16;
    big_bk = 64'(bk_q);
    big_b2 = big_bk <<< 1;
    if (vb_q >= 0) begin
      if (va_q >= 0) sxt_new = (big_bk > big_a) ? SX2 : SX1;
      else           sxt_new = (-big_bk > big_a) ? SX3 : SX2;
    end else begin
      if (va_q >= 0) sxt_new = (-big_bk > big_a) ? SX5 : SX6;
      else           sxt_new = (big_bk > big_a) ? SX4 : SX5;
    end
    case (sxt_new)
      SX1:     begin n1v = big_a - big_bk;  n2v = big_b2;          end
      SX2:     begin n1v = big_bk - big_a;  n2v = big_a + big_bk;  end
      SX3:     begin n1v = big_b2;          n2v = -big_a - big_bk; end
      SX4:     begin n1v = -big_b2;         n2v = big_bk - big_a;  end
      SX5:     begin n1v = -big_a - big_bk; n2v = big_a - big_bk;  end
      default: begin n1v = big_a + big_bk;  n2v = -big_b2;         end
    endcase
  end

  // Edge times in switching order
  logic [19:0] t_mid, t_end, ta_new, tb_new, tc_new;
  always_comb begin
    t_mid = 20'(t0h_q + 20'(t1_q));
    t_end = 20'(t_mid + 20'(t2_q));
    case (sxt_q)
      SX1:     begin ta_new = t0h_q; tb_new = t_mid; tc_new = t_end; end
      SX2:     begin tb_new = t0h_q; ta_new = t_mid; tc_new = t_end; end
      SX3:     begin tb_new = t0h_q; tc_new = t_mid; ta_new = t_end; end
      SX4:     begin tc_new = t0h_q; tb_new = t_mid; ta_new = t_end; end
      SX5:     begin tc_new = t0h_q; ta_new = t_mid; tb_new = t_end; end
      default: begin ta_new = t0h_q; tc_new = t_mid; tb_new = t_end; end
    endcase
  end

  // Dead time around each edge
  logic [8:0]  dt_half;
  logic [20:0] a_off_s, b_off_s, c_off_s;
  logic [15:0] a_on_n, b_on_n, c_on_n, a_off_n, b_off_n, c_off_n;
  always_comb begin
    dt_half = dead_time_i[9:1];
    a_on_n  = (ta_q <= 20'(dt_half)) ? 16'd0 :
              ((20'(ta_q - 20'(dt_half)) > 20'd65535) ? 16'hFFFF : 16'(ta_q - 20'(dt_half)));
    b_on_n  = (tb_q <= 20'(dt_half)) ? 16'd0 :
              ((20'(tb_q - 20'(dt_half)) > 20'd65535) ? 16'hFFFF : 16'(tb_q - 20'(dt_half)));
    c_on_n  = (tc_q <= 20'(dt_half)) ? 16'd0 :
              ((20'(tc_q - 20'(dt_half)) > 20'd65535) ? 16'hFFFF : 16'(tc_q - 20'(dt_half)));
    a_off_s = 21'(ta_q) + 21'(dt_half);
    b_off_s = 21'(tb_q) + 21'(dt_half);
    c_off_s = 21'(tc_q) + 21'(dt_half);
    a_off_n = (a_off_s > 21'd65535) ? 16'hFFFF : 16'(a_off_s);
    b_off_n = (b_off_s > 21'd65535) ? 16'hFFFF : 16'(b_off_s);
    c_off_n = (c_off_s > 21'd65535) ? 16'hFFFF : 16'(c_off_s);
  end

  // Integrators: advance only when the vector was not limited
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_d_q <= '0;
      integ_q_q <= '0;
    end else begin
      if (cmd_i.op == OP_INTD && !lim_q) begin
        integ_d_q <= 32'(sat_s(64'(integ_d_q) + p64, 32));
      end
      if (cmd_i.op == OP_INTQ && !lim_q) begin
        integ_q_q <= 32'(sat_s(64'(integ_q_q) + p64, 32));
      end
    end
  end

  // Working registers, one operation per cycle
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        p_q  <= rotor_angle_i & ANG_MASK;
        td_q <= target_d_i;
        tq_q <= target_q_i;
        ia_q <= current_a_i;
        ib_q <= current_b_i;
      end
      OP_SIN_X2: x2_q <= 16'(sh15);
      OP_SIN_U:  u_q  <= 16'(64'(SIN_B) - sh15);
      OP_SIN_W:  w_q  <= 16'(64'(SIN_A) - sh15);
      OP_SIN_Y: begin
        if (cmd_i.sel) c_q <= sin_val;
        else           s_q <= sin_val;
      end
      OP_CLARKE: begin
        ial_q <= CW'(sat_s(64'(ia_q), CW));
        ibe_q <= CW'(sat_s(rnd_s(p64, 16), CW));
      end
      OP_PD1: acc_q <= 50'(p64);
      OP_PD2: id_q  <= CW'(sat_s(rnd_s(acc64 + p64, 15), CW));
      OP_PQ1: acc_q <= 50'(p64);
      OP_PQ2: iq_q  <= CW'(sat_s(rnd_s(acc64 - p64, 15), CW));
      OP_ERR: begin
        ed_q <= EW'(64'(td_q) - 64'(id_q));
        eq_q <= EW'(64'(tq_q) - 64'(iq_q));
      end
      OP_VD: vd_q <= 24'(sat_s(rnd_s(64'(integ_d_q) + p64, 16), VOLT_WIDTH));
      OP_VQ: vq_q <= 24'(sat_s(rnd_s(64'(integ_q_q) + p64, 16), VOLT_WIDTH));
      OP_M2A: acc_q <= 50'(p64);
      OP_M2B: begin
        lim_q    <= lim_new;
        rem_q    <= m2_new;
        res_q    <= '0;
        sq_bit_q <= 49'(1) << 48;
      end
      OP_SQ_STEP: begin
        if (rem_q >= sq_try) begin
          rem_q <= 49'(rem_q - sq_try);
          res_q <= 49'((res_q >> 1) + sq_bit_q);
        end else begin
          res_q <= res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      OP_DIV_INIT: begin
        num_q <= 40'(p64);
        dsh_q <= 41'(res_q[24:0]) << 15;
        quo_q <= '0;
      end
      OP_DIV_STEP: begin
        if (41'(num_q) >= dsh_q) begin
          num_q <= 40'(41'(num_q) - dsh_q);
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          quo_q <= {quo_q[14:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
      end
      OP_DIV_END: begin
        if (cmd_i.sel) vq_q <= (vq_q < 0) ? -24'(quo_q) : 24'(quo_q);
        else           vd_q <= (vd_q < 0) ? -24'(quo_q) : 24'(quo_q);
      end
      OP_IBUS1: acc_q  <= 50'(p64);
      OP_IBUS2: ibus_q <= 32'(sat_s(acc64 + p64, 32));
      OP_IPA1:  acc_q  <= 50'(p64);
      OP_IPA2:  va_q   <= 18'(rnd_s(acc64 - p64, 15));
      OP_IPB1:  acc_q  <= 50'(p64);
      OP_IPB2:  vb_q   <= 18'(rnd_s(acc64 + p64, 15));
      OP_BK:    bk_q   <= 36'(p64);
      OP_SEXT: begin
        sxt_q <= sxt_new;
        n1_q  <= 37'(n1v);
        n2_q  <= 37'(n2v);
      end
      OP_T1: t1_q <= (tv < 0) ? 18'd0 : 18'(tv);
      OP_T2: t2_q <= (tv < 0) ? 18'd0 : 18'(tv);
      OP_T0: t0h_q <= (t0v < 0) ? 20'd0 : 20'(t0v >>> 1);
      OP_TS: begin
        ta_q <= ta_new;
        tb_q <= tb_new;
        tc_q <= tc_new;
      end
      OP_OUT: begin
        a_on_q     <= a_on_n;
        a_off_q    <= a_off_n;
        b_on_q     <= b_on_n;
        b_off_q    <= b_off_n;
        c_on_q     <= c_on_n;
        c_off_q    <= c_off_n;
        out_ibus_q <= ibus_q;
        out_lim_q  <= lim_q;
      end
      default: ;
    endcase
  end

  assign stat_o.limited         = lim_q;
  assign phase_a_on_o           = a_on_q;
  assign phase_a_off_o          = a_off_q;
  assign phase_b_on_o           = b_on_q;
  assign phase_b_off_o          = b_off_q;
  assign phase_c_on_o           = c_on_q;
  assign phase_c_off_o          = c_off_q;
  assign bus_current_estimate_o = out_ibus_q;
  assign voltage_limited_o      = out_lim_q;

endmodule

@@ design/foc_current_loop_svm.sv @@
// One item is processed at a time by the shared multiplier sequence; when the vector is
// limited, the 25-step square root and two 16-step restoring divides are added.
// A new item is taken as soon as the previous result sits in the output register.
// Reset (async, active low) restores config defaults and clears both integrators.
`timescale 1ns / 1ps
module foc_current_loop_svm #(
  parameter int unsigned CurrentWidth = focs_pkg::CURRENT_WIDTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // target_d, target_q, current_a, current_b, rotor_angle (16 bits each)
  input  logic [79:0]  s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // phase_a_on, phase_a_off, phase_b_on, phase_b_off, phase_c_on, phase_c_off (16 each),
  // bus_current_estimate (32), voltage_limited (1), zero pad (7)
  output logic [135:0] m_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);
  import focs_pkg::*;

  logic [15:0] kp_q, ki_q, half_q;
  logic [9:0]  dead_q;
  focs_cmd_t   cmd;
  focs_stat_t  stat;
  logic [15:0] a_on, a_off, b_on, b_off, c_on, c_off;
  logic signed [31:0] ibus;
  logic        lim;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= 16'd16777;
      ki_q   <= 16'd5243;
      half_q <= 16'd6250;
      dead_q <= 10'd20;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KP:   kp_q   <= cfg_data_i;
        REG_KI:   ki_q   <= cfg_data_i;
        REG_HALF: half_q <= cfg_data_i;
        REG_DEAD: dead_q <= cfg_data_i[9:0];
        default:  ;
      endcase
    end
  end

  focs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  focs_dp #(
    .CurrentWidth (CurrentWidth)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .stat_o                 (stat),
    .kp_i                   (kp_q),
    .ki_i                   (ki_q),
    .half_period_i          (half_q),
    .dead_time_i            (dead_q),
    .target_d_i             (s_axis_tdata[15:0]),
    .target_q_i             (s_axis_tdata[31:16]),
    .current_a_i            (s_axis_tdata[47:32]),
    .current_b_i            (s_axis_tdata[63:48]),
    .rotor_angle_i          (s_axis_tdata[79:64]),
    .phase_a_on_o           (a_on),
    .phase_a_off_o          (a_off),
    .phase_b_on_o           (b_on),
    .phase_b_off_o          (b_off),
    .phase_c_on_o           (c_on),
    .phase_c_off_o          (c_off),
    .bus_current_estimate_o (ibus),
    .voltage_limited_o      (lim)
  );

  assign m_axis_tdata = {7'd0, lim, ibus, c_off, c_on, b_off, b_on, a_off, a_on};

  // One item in flight: a taken beat closes the input until the result reaches the output register
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready while an item is in progress");

  // The result register load always raises output valid
  a_out_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == OP_OUT) |=> m_axis_tvalid)
    else $error("result loaded without output valid");

  // While idle the datapath runs no step other than a load
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (cmd.op == OP_NOP || cmd.op == OP_LOAD))
    else $error("datapath step issued while idle");

endmodule

@@ bench/foc_checker.sv @@
// Checker for the FOC current loop: predicts each result and compares the output beats.
`timescale 1ns / 1ps
module foc_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [79:0]  s_axis_tdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] m_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  output int           errors_o,
  output int           pending_o
);
  import focs_pkg::*;

  typedef struct {
    longint a_on, a_off, b_on, b_off, c_on, c_off;
    longint bus_current;
    longint limited;
  } pwm_result_t;

  typedef enum int {SX1, SX2, SX3, SX4, SX5, SX6} sextant_e;

  localparam longint TwoInvSqrt3 = 75674;

  // Mirrored registers and integrators
  longint kp, ki, half_period, dead;
  longint integ_d, integ_q;
  pwm_result_t expected_q[$];
  int errors;

  assign errors_o  = errors;
  assign pending_o = expected_q.size();

  function automatic longint sat_w(longint v, int w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // Q15 quarter-wave polynomial sine, folded to four quadrants
  function automatic longint sine_q15(logic [15:0] p);
    longint r, x, x2, u, w, y;
    r  = longint'(p[13:0]);
    x  = p[14] ? (16384 - r) * 2 : r * 2;
    x2 = (x * x) >> 15;
    u  = longint'(SIN_B) - ((longint'(SIN_C) * x2) >> 15);
    w  = longint'(SIN_A) - ((x2 * u) >> 15);
    y  = (x * w) >> 15;
    if (y > 32767) y = 32767;
    return p[15] ? -y : y;
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint dwell(longint num, longint h);
    longint t;
    t = (num * h) >>> 31;
    return (t < 0) ? 0 : t;
  endfunction

  function automatic longint clip16(longint v);
    return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
  endfunction

  // One PWM period of the current loop; advances the integrators unless the vector is limited
  function automatic pwm_result_t run_period(logic [79:0] beat);
    pwm_result_t res;
    longint td, tq, ia, ib, s, c, ial, ibe, id, iq, ed, eq, vd, vq, mag, ad, aq;
    longint va, vb, a, bk, b2, n1, n2, t1, t2, t0, hd;
    longint t[3];
    longint unsigned m2;
    logic [15:0] p;
    sextant_e sx;
    int o0, o1, o2;
    td = longint'($signed(beat[15:0]));
    tq = longint'($signed(beat[31:16]));
    ia = longint'($signed(beat[47:32]));
    ib = longint'($signed(beat[63:48]));
    p  = beat[79:64] & ANG_MASK;
    s  = sine_q15(p);
    c  = sine_q15(p + 16'd16384);

    // Clarke and Park
    ial = sat_w(ia, CURRENT_WIDTH);
    ibe = sat_w(round_shr((ia + 2 * ib) * longint'(INV_SQRT3_Q16), 16), CURRENT_WIDTH);
    id  = sat_w(round_shr(c * ial + s * ibe, 15), CURRENT_WIDTH);
    iq  = sat_w(round_shr(c * ibe - s * ial, 15), CURRENT_WIDTH);
    ed  = td - id;
    eq  = tq - iq;

    // PI with vector limit and integrator hold
    vd = sat_w(round_shr(integ_d + ed * kp, 16), VOLT_WIDTH);
    vq = sat_w(round_shr(integ_q + eq * kp, 16), VOLT_WIDTH);
    m2 = longint'(vd * vd) + longint'(vq * vq);
    res.limited = (m2 > longint'(VOLT_LIMIT) * longint'(VOLT_LIMIT)) ? 1 : 0;
    if (res.limited != 0) begin
      mag = isqrt(m2);
      ad  = ((vd < 0) ? -vd : vd) * longint'(VOLT_LIMIT) / mag;
      aq  = ((vq < 0) ? -vq : vq) * longint'(VOLT_LIMIT) / mag;
      vd  = (vd < 0) ? -ad : ad;
      vq  = (vq < 0) ? -aq : aq;
    end else begin
      integ_d = sat_w(integ_d + ed * ki, 32);
      integ_q = sat_w(integ_q + eq * ki, 32);
    end
    res.bus_current = sat_w(vd * id + vq * iq, 32);

    // Inverse Park and sextant pick
    va = round_shr(c * vd - s * vq, 15);
    vb = round_shr(c * vq + s * vd, 15);
    a  = va * 65536;
    bk = vb * longint'(INV_SQRT3_Q16);
    b2 = vb * TwoInvSqrt3;
    if (vb >= 0) sx = (va >= 0) ? ((bk > a) ? SX2 : SX1) : ((-bk > a) ? SX3 : SX2);
    else         sx = (va >= 0) ? ((-bk > a) ? SX5 : SX6) : ((bk > a) ? SX4 : SX5);
    case (sx)
      SX1:     begin n1 = a - bk;  n2 = b2;      o0 = 0; o1 = 1; o2 = 2; end
      SX2:     begin n1 = -a + bk; n2 = a + bk;  o0 = 1; o1 = 0; o2 = 2; end
      SX3:     begin n1 = b2;      n2 = -a - bk; o0 = 1; o1 = 2; o2 = 0; end
      SX4:     begin n1 = -b2;     n2 = -a + bk; o0 = 2; o1 = 1; o2 = 0; end
      SX5:     begin n1 = -a - bk; n2 = a - bk;  o0 = 2; o1 = 0; o2 = 1; end
      default: begin n1 = a + bk;  n2 = -b2;     o0 = 0; o1 = 2; o2 = 1; end
    endcase
    t1 = dwell(n1, half_period);
    t2 = dwell(n2, half_period);
    t0 = half_period - t1 - t2;
    if (t0 < 0) t0 = 0;
    t[o0] = t0 / 2;
    t[o1] = t[o0] + t1;
    t[o2] = t[o1] + t2;

    // Dead time split around each edge
    hd = dead / 2;
    res.a_on  = clip16(t[0] - hd);
    res.a_off = clip16(t[0] + hd);
    res.b_on  = clip16(t[1] - hd);
    res.b_off = clip16(t[1] + hd);
    res.c_on  = clip16(t[2] - hd);
    res.c_off = clip16(t[2] + hd);
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  // Watch config writes, input beats and output beats
  always @(posedge clk_i or negedge rst_ni) begin
    pwm_result_t want;
    if (!rst_ni) begin
      kp          = 16777;
      ki          = 5243;
      half_period = 6250;
      dead        = 20;
      integ_d     = 0;
      integ_q     = 0;
      expected_q.delete();
      errors      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KP:   kp = longint'(cfg_data_i);
          REG_KI:   ki = longint'(cfg_data_i);
          REG_HALF: half_period = longint'(cfg_data_i);
          REG_DEAD: dead = longint'(cfg_data_i[9:0]);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(run_period(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          // Output beat count against expected results
          report_mismatch("unexpected output beat", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata[15:0] != want.a_on[15:0])
            report_mismatch("phase_a_on", m_axis_tdata[15:0], want.a_on);
          if (m_axis_tdata[31:16] != want.a_off[15:0])
            report_mismatch("phase_a_off", m_axis_tdata[31:16], want.a_off);
          if (m_axis_tdata[47:32] != want.b_on[15:0])
            report_mismatch("phase_b_on", m_axis_tdata[47:32], want.b_on);
          if (m_axis_tdata[63:48] != want.b_off[15:0])
            report_mismatch("phase_b_off", m_axis_tdata[63:48], want.b_off);
          if (m_axis_tdata[79:64] != want.c_on[15:0])
            report_mismatch("phase_c_on", m_axis_tdata[79:64], want.c_on);
          if (m_axis_tdata[95:80] != want.c_off[15:0])
            report_mismatch("phase_c_off", m_axis_tdata[95:80], want.c_off);
          if (m_axis_tdata[127:96] != want.bus_current[31:0])
            report_mismatch("bus_current_estimate",
                            longint'($signed(m_axis_tdata[127:96])), want.bus_current);
          if (m_axis_tdata[128] != want.limited[0])
            report_mismatch("voltage_limited", m_axis_tdata[128], want.limited);
        end
      end
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for the FOC current loop: stimulus, config phases and verdict.
`timescale 1ns / 1ps
module tb_top;
  import focs_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [79:0]  s_axis_tdata = '0;   // target_d, target_q, current_a, current_b, rotor_angle
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] m_axis_tdata;        // a_on, a_off, b_on, b_off, c_on, c_off, ibus, limited
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [15:0]  cfg_data_i = '0;
  int           errors;
  int           pending;
  int           send_gap_pct;
  int           recv_idle_pct;
  int           sent;

  localparam int RandomItems = 1400;

  always #2 clk_i = ~clk_i;

  foc_current_loop_svm i_dut (.*);

  foc_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  // Result side back-pressure
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Drive one beat, holding it until accepted; leaves at a falling edge
  task automatic send_beat(logic [15:0] td, logic [15:0] tq, logic [15:0] ia,
                           logic [15:0] ib, logic [15:0] ang);
    logic rdy;
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {ang, ib, ia, tq, td};
    s_axis_tvalid = 1'b1;
    do begin
      rdy = s_axis_tready;
      @(negedge clk_i);
    end while (!rdy);
    s_axis_tvalid = 1'b0;
    sent++;
  endtask

  // Register write with the block idle
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_current(int shape);
    case (shape)
      0:       return 16'($signed($urandom_range(1024)) - 512);
      1:       return 16'($signed($urandom_range(8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int shape;
    logic [15:0] kp_v, ki_v, h_v, dt_v;
    send_gap_pct  = 0;
    recv_idle_pct = 0;
    sent = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, angle quadrants, current and voltage overflow
    send_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_beat(16'h0100, 16'h0200, 16'h0080, 16'hFF80, 16'h4000);
    send_beat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_beat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_beat(16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'hC000);
    send_beat(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h003F);
    send_beat(16'h0050, 16'hFFB0, 16'h0010, 16'h0020, 16'h2AAA);
    send_beat(16'hFFB0, 16'h0050, 16'hFFF0, 16'h0020, 16'h5555);
    send_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hAAAA);
    drain();
    write_reg(REG_KP, 16'hFFFF);
    write_reg(REG_KI, 16'hFFFF);
    write_reg(REG_HALF, 16'd0);
    write_reg(REG_DEAD, 16'd1023);
    send_beat(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h1234);
    send_beat(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hEDCB);
    send_beat(16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    drain();
    write_reg(REG_KP, 16'd0);
    write_reg(REG_KI, 16'd0);
    write_reg(REG_HALF, 16'hFFFF);
    write_reg(REG_DEAD, 16'd0);
    send_beat(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h9000);
    send_beat(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h7000);
    send_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    drain();
    write_reg(REG_HALF, 16'd15);
    write_reg(REG_DEAD, 16'd1);
    send_beat(16'h0100, 16'hFF00, 16'h0020, 16'h0040, 16'h6000);
    send_beat(16'hFF00, 16'h0100, 16'hFFE0, 16'h0040, 16'hE000);
    drain();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin
          kp_v = 16'($urandom_range(30000));
          ki_v = 16'($urandom_range(8000));
          h_v  = 16'($urandom_range(20000, 16));
          dt_v = 16'($urandom_range(200));
        end
        1: begin
          kp_v = 16'hFFFF;
          ki_v = 16'($urandom_range(1));
          h_v  = 16'hFFFF;
          dt_v = 16'd1023;
        end
        2: begin
          kp_v = 16'($urandom_range(5));
          ki_v = 16'hFFFF;
          h_v  = 16'($urandom_range(15));
          dt_v = 16'($urandom_range(1));
        end
        default: begin
          kp_v = 16'($urandom);
          ki_v = 16'($urandom);
          h_v  = 16'($urandom);
          dt_v = 16'($urandom_range(1023));
        end
      endcase
      drain();
      write_reg(REG_KP, kp_v);
      write_reg(REG_KI, ki_v);
      write_reg(REG_HALF, h_v);
      write_reg(REG_DEAD, dt_v);
      for (int n = 0; n < RandomItems / 12; n++) begin
        // Idling profile follows overall progress
        if (ph < 4) begin
          send_gap_pct  = 22;
          recv_idle_pct = 78;
        end else if (ph < 8) begin
          send_gap_pct  = 78;
          recv_idle_pct = 22;
        end else begin
          send_gap_pct  = 0;
          recv_idle_pct = 0;
        end
        shape = $urandom_range(9) < 5 ? 0 : ($urandom_range(9) < 6 ? 1 : 2);
        send_beat(pick_current(shape), pick_current(shape), pick_current(shape),
                  pick_current(shape), 16'($urandom));
      end
    end

    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #4ms;
    $display("FAILURE");
    $finish;
  end

endmodule
